>>> design/kwm_pkg.sv
// Shared types and codes for the k-way sorted merge block.
package kwm_pkg;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_TAKE   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [3:0] LIU_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_UNUSED = 2'd3
  } kwm_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } kwm_state_t;

endpackage

>>> design/kwm_if.sv
// Valid/ready channel interfaces for the merge block input and result streams.
interface kwm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [2:0]         list_index;
  logic signed [31:0] value;

  modport source (output valid, output mode, output list_index, output value, input ready);
  modport sink (input valid, input mode, input list_index, input value, output ready);
endinterface

interface kwm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [2:0]         from_list;
  logic [1:0]         status;

  modport source (output valid, output out_value, output from_list, output status,
                  input ready);
  modport sink (input valid, input out_value, input from_list, input status,
                output ready);
endinterface

>>> design/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/kwm_min_unit.sv
// Shared signed comparator that tracks the smallest candidate head and its list.
module kwm_min_unit #(
  parameter int LW = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               cand_valid,
  input  logic signed [31:0] cand_val,
  input  logic [LW-1:0]      cand_idx,
  output logic               found,
  output logic signed [31:0] best_val,
  output logic [LW-1:0]      best_idx
);

  logic               found_r, found_nxt;
  logic signed [31:0] best_val_r, best_val_nxt;
  logic [LW-1:0]      best_idx_r, best_idx_nxt;

  always_comb begin
    found_nxt    = found_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    if (start) begin
      found_nxt = 1'b0;
    end else if (cand_valid && (!found_r || (cand_val < best_val_r))) begin
      found_nxt    = 1'b1;
      best_val_nxt = cand_val;
      best_idx_nxt = cand_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      best_val_r <= '0;
      best_idx_r <= '0;
    end else begin
      found_r    <= found_nxt;
      best_val_r <= best_val_nxt;
      best_idx_r <= best_idx_nxt;
    end
  end

  assign found    = found_r;
  assign best_val = best_val_r;
  assign best_idx = best_idx_r;

endmodule

>>> design/k_way_sorted_merge.sv
// Top level of the k-way sorted merge: list bookkeeping, sequencer and result register.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      mode, list_index, value
//   out_ch    out  valid/ready      out_value, from_list, status
//   cfg       in   cfg_we           cfg_wdata (lists_in_use)
//
// Append, clear: the transaction passes through S_EXEC into the result register.
// Take: S_SCAN over the n active lists, then S_DONE; the single comparator sees one head per cycle.
// Reset clears pointers and counts at once; no sweep of the list RAM.
// A full result register holds the sequencer in its last state until drained.
module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int LISTS = 8,
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  kwm_in_if.sink     in_ch,
  kwm_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  localparam int LW = $clog2(LISTS);
  localparam int NW = LW + 1;
  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(LISTS * DEPTH);

  kwm_state_t state_r, state_nxt;
  logic [3:0] cfg_r;

  logic [PW-1:0] hp_r [LISTS];
  logic [PW-1:0] hp_nxt [LISTS];
  logic [FW-1:0] fc_r [LISTS];
  logic [FW-1:0] fc_nxt [LISTS];

  logic [1:0]         mode_r;
  logic [2:0]         idx_r;
  logic signed [31:0] val_r;

  logic [NW-1:0] scan_i_r, scan_i_nxt;
  logic          pend_r, pend_nxt;
  logic [LW-1:0] pend_idx_r, pend_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic [2:0]         out_list_r, out_list_nxt;
  kwm_status_t        out_status_r, out_status_nxt;

  logic [NW-1:0] n_act;
  logic [LW-1:0] idx_l, sel_l;
  logic [PW-1:0] hp_sel;
  logic [FW-1:0] fc_sel;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] tail;
  logic          slot_free, accept, min_start;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  logic               found;
  logic signed [31:0] best_val;
  logic [LW-1:0]      best_idx;

  function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] l, input logic [PW-1:0] p);
    slot_addr = AW'(AW'(l) * AW'(DEPTH)) + AW'(p);
  endfunction

  assign n_act     = (32'(cfg_r) >= LISTS) ? NW'(LISTS) : NW'(cfg_r);
  assign idx_l     = LW'(32'(idx_r));
  assign slot_free = !out_valid_r || out_ch.ready;
  assign accept    = in_ch.valid && in_ch.ready;
  assign min_start = accept;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    case (state_r)
      S_EXEC:  sel_l = idx_l;
      S_SCAN:  sel_l = scan_i_r[LW-1:0];
      default: sel_l = best_idx;
    endcase
  end

  assign hp_sel   = hp_r[sel_l];
  assign fc_sel   = fc_r[sel_l];
  assign tail_sum = {1'b0, hp_sel} + (PW + 1)'(fc_sel);
  assign tail     = (tail_sum >= (PW + 1)'(DEPTH)) ? PW'(tail_sum - (PW + 1)'(DEPTH))
                                                   : tail_sum[PW-1:0];

  always_comb begin
    state_nxt      = state_r;
    hp_nxt         = hp_r;
    fc_nxt         = fc_r;
    scan_i_nxt     = scan_i_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_list_nxt   = out_list_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_addr(idx_l, tail);
    ram_raddr      = slot_addr(sel_l, hp_sel);
    case (state_r)
      S_IDLE: begin
        scan_i_nxt = '0;
        pend_nxt   = 1'b0;
        if (accept) begin
          state_nxt = (in_ch.mode == MODE_TAKE) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_list_nxt   = '0;
          out_status_nxt = ST_OK;
          if (mode_r == MODE_APPEND) begin
            if (32'(idx_r) >= 32'(n_act)) begin
              out_status_nxt = ST_UNUSED;
            end else if (fc_sel == FW'(DEPTH)) begin
              out_status_nxt = ST_FULL;
            end else begin
              ram_we        = 1'b1;
              fc_nxt[idx_l] = fc_sel + FW'(1);
            end
          end else if (mode_r == MODE_CLEAR) begin
            for (int i = 0; i < LISTS; i++) begin
              hp_nxt[i] = '0;
              fc_nxt[i] = '0;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_i_r != n_act) begin
          pend_nxt     = (fc_sel != '0);
          pend_idx_nxt = sel_l;
          scan_i_nxt   = scan_i_r + NW'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (found) begin
            out_value_nxt  = best_val;
            out_list_nxt   = 3'(best_idx);
            out_status_nxt = ST_OK;
            hp_nxt[best_idx] = (hp_sel == PW'(DEPTH - 1)) ? '0 : hp_sel + PW'(1);
            fc_nxt[best_idx] = fc_sel - FW'(1);
          end else begin
            out_value_nxt  = '0;
            out_list_nxt   = '0;
            out_status_nxt = ST_EMPTY;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= LIU_RESET;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      scan_i_r    <= '0;
      for (int i = 0; i < LISTS; i++) begin
        hp_r[i] <= '0;
        fc_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      scan_i_r    <= scan_i_nxt;
      hp_r        <= hp_nxt;
      fc_r        <= fc_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
    if (accept) begin
      mode_r <= in_ch.mode;
      idx_r  <= in_ch.list_index;
      val_r  <= in_ch.value;
    end
    pend_idx_r   <= pend_idx_nxt;
    out_value_r  <= out_value_nxt;
    out_list_r   <= out_list_nxt;
    out_status_r <= out_status_nxt;
  end

  kwm_ram #(
    .WIDTH(32),
    .DEPTH(LISTS * DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(val_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  kwm_min_unit #(
    .LW(LW)
  ) u_min (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (min_start),
    .cand_valid(pend_r && (state_r == S_SCAN)),
    .cand_val  (ram_rdata),
    .cand_idx  (pend_idx_r),
    .found     (found),
    .best_val  (best_val),
    .best_idx  (best_idx)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.from_list = out_list_r;
  assign out_ch.status    = out_status_r;

`ifndef SYNTHESIS
  a_take_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.mode == MODE_TAKE) |=> (state_r == S_SCAN))
    else $error("take transaction did not start a scan");

  a_rose_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_DONE))
    else $error("result appeared outside an execute step");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(fc_sel) <= DEPTH))
    else $error("fill count above list depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && found) |-> (fc_r[best_idx] != '0))
    else $error("winning list is empty");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the k-way sorted merge: random traffic, prediction, result check.
`timescale 1ns / 1ps

module tb;
  import kwm_pkg::*;

  localparam int LISTS = 8;
  localparam int DEPTH = 16;
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int PHASES = 8;
  localparam int TXNS_PER_PHASE = 103;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         list_index;
    logic signed [31:0] value;
    bit                 drain_first;
  } merge_txn_t;

  typedef struct {
    logic signed [31:0] out_value;
    logic [2:0]         from_list;
    kwm_status_t        status;
  } merge_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  kwm_in_if  in_ch ();
  kwm_out_if out_ch ();

  k_way_sorted_merge #(
    .LISTS(LISTS),
    .DEPTH(DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predicted state of the lists
  logic signed [31:0] list_mem [LISTS][DEPTH];
  int                 head_ptr [LISTS] = '{default: 0};
  int                 fill_cnt [LISTS] = '{default: 0};
  logic [3:0]         lists_in_use = LIU_RESET;

  merge_txn_t    txn_backlog[$];
  merge_result_t predicted_results[$];
  merge_txn_t    cur_txn;
  int            issued_cnt = 0;
  int            accepted_cnt = 0;
  int            error_cnt = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  // stimulus generator bookkeeping: last value appended per list keeps lists ascending
  longint gen_last [LISTS];
  int     gen_lists = LISTS;

  function automatic merge_result_t merge_predict(merge_txn_t t);
    merge_result_t      r;
    int                 eff;
    int                 best;
    int                 tail;
    bit                 found;
    logic signed [31:0] best_val;
    r = '{out_value: '0, from_list: '0, status: ST_OK};
    eff = (lists_in_use > LISTS) ? LISTS : int'(lists_in_use);
    found = 1'b0;
    best = 0;
    best_val = '0;
    case (t.mode)
      MODE_APPEND: begin
        if (int'(t.list_index) >= eff) begin
          r.status = ST_UNUSED;
        end else if (fill_cnt[t.list_index] >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tail = (head_ptr[t.list_index] + fill_cnt[t.list_index]) % DEPTH;
          list_mem[t.list_index][tail] = t.value;
          fill_cnt[t.list_index]++;
        end
      end
      MODE_TAKE: begin
        for (int i = 0; i < eff; i++) begin
          if (fill_cnt[i] != 0 && (!found || list_mem[i][head_ptr[i]] < best_val)) begin
            found = 1'b1;
            best = i;
            best_val = list_mem[i][head_ptr[i]];
          end
        end
        if (!found) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = best_val;
          r.from_list = best[2:0];
          head_ptr[best] = (head_ptr[best] + 1) % DEPTH;
          fill_cnt[best]--;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < LISTS; i++) begin
          head_ptr[i] = 0;
          fill_cnt[i] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        lists_in_use = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(merge_predict(cur_txn));
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (txn_backlog.size() != 0
            && !(txn_backlog[0].drain_first && predicted_results.size() != 0)
            && $urandom_range(99) >= send_idle_pct) begin
          cur_txn = txn_backlog.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.mode       <= cur_txn.mode;
          in_ch.list_index <= cur_txn.list_index;
          in_ch.value      <= cur_txn.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    merge_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result transaction: out_value %0d from_list %0d status %0d",
                 out_ch.out_value, out_ch.from_list, out_ch.status);
          error_cnt++;
        end else begin
          e = predicted_results.pop_front();
          if (out_ch.out_value !== e.out_value) begin
            $error("out_value mismatch: expected %0d, actual %0d", e.out_value,
                   out_ch.out_value);
            error_cnt++;
          end
          if (out_ch.from_list !== e.from_list) begin
            $error("from_list mismatch: expected %0d, actual %0d", e.from_list,
                   out_ch.from_list);
            error_cnt++;
          end
          if (out_ch.status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, out_ch.status);
            error_cnt++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_txn(logic [1:0] m, logic [2:0] idx, logic signed [31:0] v,
                          bit hold = 1'b0);
    txn_backlog.push_back('{mode: m, list_index: idx, value: v, drain_first: hold});
    issued_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != issued_cnt || predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_lists_in_use(logic [3:0] v);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_lists = (v > LISTS) ? LISTS : int'(v);
  endtask

  function automatic longint start_value();
    if ($urandom_range(1) == 0) begin
      return longint'($urandom_range(40)) - 20;
    end
    return longint'($signed($urandom())) >>> $urandom_range(8);
  endfunction

  function automatic logic [2:0] pick_list();
    if (gen_lists == 0) begin
      return 3'($urandom_range(LISTS - 1));
    end
    return 3'($urandom_range(gen_lists - 1));
  endfunction

  task automatic append_ascending(logic [2:0] idx, bit hold = 1'b0);
    int     r;
    longint nxt;
    r = $urandom_range(99);
    if (r < 20) begin
      nxt = gen_last[idx];
    end else if (r < 70) begin
      nxt = gen_last[idx] + $urandom_range(1, 1000);
    end else begin
      nxt = gen_last[idx] + $urandom_range(1, 1 << 24);
    end
    if (nxt > longint'(VAL_MAX)) begin
      nxt = longint'(VAL_MAX);
    end
    gen_last[idx] = nxt;
    push_txn(MODE_APPEND, idx, nxt[31:0], hold);
  endtask

  task automatic random_phase(int count);
    int         n;
    int         r;
    int         hold_at;
    logic [2:0] idx;
    n = 0;
    hold_at = $urandom_range(count / 4, 3 * count / 4);
    while (n < count) begin
      r = $urandom_range(99);
      if (n == hold_at) begin
        append_ascending(pick_list(), 1'b1);
        n++;
      end else if (r < 4) begin
        idx = pick_list();
        for (int j = 0; j < DEPTH + 2; j++) append_ascending(idx);
        n += DEPTH + 2;
      end else if (r < 46) begin
        append_ascending(pick_list());
        n++;
      end else if (r < 52) begin
        push_txn(MODE_APPEND, 3'($urandom_range(LISTS - 1)), $urandom());
        n++;
      end else if (r < 92) begin
        push_txn(MODE_TAKE, 3'($urandom()), $urandom());
        n++;
      end else if (r < 96) begin
        push_txn(MODE_CLEAR, 3'($urandom()), $urandom());
        for (int i = 0; i < LISTS; i++) gen_last[i] = start_value();
        n++;
      end else begin
        push_txn(MODE_NOP, 3'($urandom()), $urandom());
        n++;
      end
    end
  endtask

  initial begin
    logic [3:0] cfg_plan [PHASES];
    cfg_plan         = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd9, 4'd5};
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = '0;
    in_ch.list_index = '0;
    in_ch.value      = '0;
    out_ch.ready     = 1'b0;
    for (int i = 0; i < LISTS; i++) gen_last[i] = start_value();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      write_lists_in_use(cfg_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (p == 0) begin
        // empty take, extremes, cross-list tie at the minimum, ignored mode
        push_txn(MODE_TAKE, 3'd0, 32'sd0);
        push_txn(MODE_APPEND, 3'd0, VAL_MIN);
        push_txn(MODE_APPEND, 3'd1, VAL_MAX);
        push_txn(MODE_APPEND, 3'd7, -32'sd1);
        push_txn(MODE_APPEND, 3'd3, VAL_MIN);
        push_txn(MODE_TAKE, 3'd7, VAL_MAX);
        push_txn(MODE_TAKE, 3'd0, 32'sd0);
        push_txn(MODE_TAKE, 3'd0, 32'sd0);
        push_txn(MODE_NOP, 3'd5, 32'sh5555_5555);
        // fill one list past its depth
        for (int j = 0; j <= DEPTH; j++) push_txn(MODE_APPEND, 3'd4, 32'(j * 3 - 20));
        push_txn(MODE_CLEAR, 3'd2, 32'shaaaa_aaaa);
        push_txn(MODE_TAKE, 3'd0, 32'sd0);
        for (int i = 0; i < LISTS; i++) gen_last[i] = start_value();
      end
      random_phase(TXNS_PER_PHASE);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
